// ===== design/toroidal_life_generation_engine_assert.svh =====
// assertion macros for the toroidal life generation engine
`ifndef TOROIDAL_LIFE_GENERATION_ENGINE_ASSERT_SVH
`define TOROIDAL_LIFE_GENERATION_ENGINE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TLGE_ASSERT_IMP(lbl, clk, rstn, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
		else $error("tlge assertion failed");
`define TLGE_ASSERT_NXT(lbl, clk, rstn, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
		else $error("tlge assertion failed");
`else
`define TLGE_ASSERT_IMP(lbl, clk, rstn, pre, post)
`define TLGE_ASSERT_NXT(lbl, clk, rstn, pre, post)
`endif
`endif

// ===== design/tlge_pkg.sv =====
// shared types and constants of the toroidal life generation engine
package tlge_pkg;
	localparam int CELL_W = 2;
	localparam int COORD_W = 6;
	localparam int SIDE_W = 7;
	localparam int MIN_SIDE = 3;
	localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd64;
	localparam logic [3:0] BIRTH_COUNT = 4'd3;
	localparam logic [3:0] STAY_COUNT = 4'd2;

	typedef logic [CELL_W-1:0] cell_t;
	localparam cell_t CELL_DEAD = 2'd0;
	localparam cell_t CELL_LIVE = 2'd1;
	localparam cell_t CELL_BORN = 2'd2;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_READ = 2'd2,
		CMD_STEP = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRITE,
		ST_READ,
		ST_GEN_FIRST,
		ST_GEN_SECOND,
		ST_GEN_ROW
	} state_t;
endpackage

// ===== design/toroidal_life_generation_engine.sv =====
// top level of the toroidal life generation engine: row memory and command sequencer
//
// channel   direction  handshake                 payload
// command   in         start && !busy            cmd, coord_x, coord_y, cell_in
// result    out        done (one cycle)          cell_out
// config    in         side_in_use_we            side_in_use
//
// write and read pass through ST_WRITE or ST_READ, then raise done back in idle
// clear zeroes MAX_SIDE rows; a generation updates side rows (side = active side)
// the grid memory holds one row per word; a generation reads a row while writing one
// after reset busy stays high while the clearing pass runs
// the receiver cannot stall; done is a single cycle strobe
`include "toroidal_life_generation_engine_assert.svh"
module toroidal_life_generation_engine #(
	parameter int MAX_SIDE = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    cmd,
	input  logic [tlge_pkg::COORD_W-1:0]  coord_x,
	input  logic [tlge_pkg::COORD_W-1:0]  coord_y,
	input  logic [tlge_pkg::CELL_W-1:0]   cell_in,
	output logic                          done,
	output logic [tlge_pkg::CELL_W-1:0]   cell_out,
	input  logic                          side_in_use_we,
	input  logic [tlge_pkg::SIDE_W-1:0]   side_in_use
);
	import tlge_pkg::*;

	localparam int AW = $clog2(MAX_SIDE);
	localparam int SW = $clog2(MAX_SIDE + 1);
	localparam int CMPW = (SW > SIDE_W) ? SW : SIDE_W;
	localparam int XW = (SW > COORD_W) ? SW : COORD_W;

	typedef logic [MAX_SIDE-1:0][CELL_W-1:0] row_t;

	state_t state_q, state_d;
	logic [AW-1:0] row_q, row_d;
	logic report_q, report_d;
	logic done_q, done_d;
	cell_t cell_out_q, out_d;
	logic [SIDE_W-1:0] side_q;

	logic [SW-1:0] side_eff;
	logic [AW-1:0] last_col;
	logic in_grid;
	cell_t cell_sat;

	logic [AW-1:0] x_q;
	logic [AW-1:0] y_q;
	cell_t val_q;
	logic in_q;
	row_t prev_q, cur_q, first_q;

	logic rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	row_t rd_row, wr_row, mod_row, nxt_row, new_row;

	always_comb begin
		if (side_q < SIDE_W'(MIN_SIDE)) begin
			side_eff = SW'(MIN_SIDE);
		end else if (CMPW'(side_q) > CMPW'(MAX_SIDE)) begin
			side_eff = SW'(MAX_SIDE);
		end else begin
			side_eff = SW'(side_q);
		end
	end

	assign last_col = AW'(side_eff - 1'b1);
	assign in_grid = (XW'(coord_x) < XW'(side_eff)) && (XW'(coord_y) < XW'(side_eff));
	assign cell_sat = (cell_in > CELL_BORN) ? CELL_BORN : cell_in;

	always_comb begin
		mod_row = rd_row;
		mod_row[y_q] = val_q;
	end

	assign nxt_row = (row_q == last_col) ? first_q : rd_row;

	tlge_ram #(
		.WIDTH(CELL_W * MAX_SIDE),
		.DEPTH(MAX_SIDE)
	) u_grid (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_row),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_row)
	);

	tlge_row_eval #(
		.MAX_SIDE(MAX_SIDE)
	) u_eval (
		.prev_row(prev_q),
		.cur_row (cur_q),
		.next_row(nxt_row),
		.side    (side_eff),
		.last_col(last_col),
		.new_row (new_row)
	);

	always_comb begin
		state_d = state_q;
		row_d = row_q;
		report_d = report_q;
		rd_en = 1'b0;
		rd_addr = row_q;
		wr_en = 1'b0;
		wr_addr = row_q;
		wr_row = '0;
		done_d = 1'b0;
		out_d = CELL_DEAD;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
				if (row_q == AW'(MAX_SIDE - 1)) begin
					state_d = ST_IDLE;
					done_d = report_q;
				end else begin
					row_d = row_q + 1'b1;
				end
			end
			ST_IDLE: begin
				rd_addr = (cmd_t'(cmd) == CMD_STEP) ? last_col : AW'(coord_x);
				if (start) begin
					rd_en = 1'b1;
					unique case (cmd_t'(cmd))
						CMD_CLEAR: begin
							state_d = ST_CLEAR;
							row_d = '0;
							report_d = 1'b1;
						end
						CMD_WRITE: state_d = ST_WRITE;
						CMD_READ:  state_d = ST_READ;
						CMD_STEP:  state_d = ST_GEN_FIRST;
					endcase
				end
			end
			ST_WRITE: begin
				wr_en = in_q;
				wr_addr = x_q;
				wr_row = mod_row;
				done_d = 1'b1;
				state_d = ST_IDLE;
			end
			ST_READ: begin
				out_d = in_q ? rd_row[y_q] : CELL_DEAD;
				done_d = 1'b1;
				state_d = ST_IDLE;
			end
			ST_GEN_FIRST: begin
				rd_en = 1'b1;
				rd_addr = '0;
				state_d = ST_GEN_SECOND;
			end
			ST_GEN_SECOND: begin
				rd_en = 1'b1;
				rd_addr = AW'(1);
				row_d = '0;
				state_d = ST_GEN_ROW;
			end
			ST_GEN_ROW: begin
				wr_en = 1'b1;
				wr_row = new_row;
				rd_addr = AW'({1'b0, row_q} + 2'd2);
				if (row_q == last_col) begin
					done_d = 1'b1;
					state_d = ST_IDLE;
				end else begin
					rd_en = 1'b1;
					row_d = row_q + 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			row_q <= '0;
			report_q <= 1'b0;
			done_q <= 1'b0;
			cell_out_q <= CELL_DEAD;
			side_q <= SIDE_RESET;
		end else begin
			state_q <= state_d;
			row_q <= row_d;
			report_q <= report_d;
			done_q <= done_d;
			cell_out_q <= out_d;
			if (side_in_use_we) begin
				side_q <= side_in_use;
			end
		end
	end

	// transaction capture and generation row window
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			x_q <= AW'(coord_x);
			y_q <= AW'(coord_y);
			val_q <= cell_sat;
			in_q <= in_grid;
		end
		if (state_q == ST_GEN_FIRST) begin
			prev_q <= rd_row;
		end
		if (state_q == ST_GEN_SECOND) begin
			cur_q <= rd_row;
			first_q <= rd_row;
		end
		if (state_q == ST_GEN_ROW) begin
			prev_q <= cur_q;
			cur_q <= nxt_row;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign cell_out = cell_out_q;

	`TLGE_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`TLGE_ASSERT_IMP(a_no_same_row, clk, arst_n, wr_en && rd_en, wr_addr != rd_addr)
	`TLGE_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy)
	`TLGE_ASSERT_IMP(a_done_after_work, clk, arst_n, done, $past(state_q) != ST_IDLE)
endmodule

// ===== design/tlge_ram.sv =====
// generic simple dual port ram with registered read
module tlge_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

// ===== design/tlge_row_eval.sv =====
// next generation of one grid row from the three old rows around it
module tlge_row_eval #(
	parameter int MAX_SIDE = 64,
	localparam int AW = $clog2(MAX_SIDE),
	localparam int SW = $clog2(MAX_SIDE + 1)
) (
	input  logic [MAX_SIDE-1:0][tlge_pkg::CELL_W-1:0] prev_row,
	input  logic [MAX_SIDE-1:0][tlge_pkg::CELL_W-1:0] cur_row,
	input  logic [MAX_SIDE-1:0][tlge_pkg::CELL_W-1:0] next_row,
	input  logic [SW-1:0]                             side,
	input  logic [AW-1:0]                             last_col,
	output logic [MAX_SIDE-1:0][tlge_pkg::CELL_W-1:0] new_row
);
	import tlge_pkg::*;

	logic [MAX_SIDE-1:0] ap;
	logic [MAX_SIDE-1:0] ac;
	logic [MAX_SIDE-1:0] an;
	logic p_last;
	logic c_last;
	logic n_last;

	always_comb begin
		for (int b = 0; b < MAX_SIDE; b++) begin
			ap[b] = |prev_row[b];
			ac[b] = |cur_row[b];
			an[b] = |next_row[b];
		end
	end

	// wrap column for the leftmost lane
	assign p_last = ap[last_col];
	assign c_last = ac[last_col];
	assign n_last = an[last_col];

	for (genvar b = 0; b < MAX_SIDE; b++) begin : g_lane
		localparam int LEFT = (b == 0) ? 0 : b - 1;
		localparam int RIGHT = (b + 1) % MAX_SIDE;
		logic at_right;
		logic pl, pr, cl, cr, nl, nr;
		logic [3:0] cnt;

		assign at_right = (last_col == AW'(b));
		assign pl = (b == 0) ? p_last : ap[LEFT];
		assign cl = (b == 0) ? c_last : ac[LEFT];
		assign nl = (b == 0) ? n_last : an[LEFT];
		assign pr = at_right ? ap[0] : ap[RIGHT];
		assign cr = at_right ? ac[0] : ac[RIGHT];
		assign nr = at_right ? an[0] : an[RIGHT];
		assign cnt = 4'(pl) + 4'(ap[b]) + 4'(pr) + 4'(cl) + 4'(cr)
			+ 4'(nl) + 4'(an[b]) + 4'(nr);
		assign new_row[b] = (SW'(b) >= side) ? cur_row[b] :
			(cur_row[b] == CELL_DEAD) ? ((cnt == BIRTH_COUNT) ? CELL_BORN : CELL_DEAD) :
			((cnt == STAY_COUNT || cnt == BIRTH_COUNT) ? CELL_LIVE : CELL_DEAD);
	end
endmodule
